// File: design/acrm_pkg.sv
// Shared constants, types and color stop table for the attribute color ramp.
package acrm_pkg;

    localparam int GammaTableDepthDefault = 1024;
    localparam int AttrWidthDefault       = 32;
    localparam int FracBits               = 16;
    localparam int SegBits                = 13;

    localparam logic [1:0] RangeBelow = 2'd0;
    localparam logic [1:0] RangeIn    = 2'd1;
    localparam logic [1:0] RangeAbove = 2'd2;

    localparam logic [1:0] CfgMin   = 2'd0;
    localparam logic [1:0] CfgMax   = 2'd1;
    localparam logic [1:0] CfgGamma = 2'd2;

    typedef struct packed {
        logic below;
        logic above;
        logic full;
        logic empty;
    } flags_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic rgb_t ramp_stop(input logic [3:0] idx);
        rgb_t c;
        case (idx)
            4'd0:    c = '{8'd0,   8'd0,   8'd0};
            4'd1:    c = '{8'd44,  8'd5,   8'd103};
            4'd2:    c = '{8'd3,   8'd67,  8'd67};
            4'd3:    c = '{8'd5,   8'd103, 8'd13};
            4'd4:    c = '{8'd117, 8'd124, 8'd6};
            4'd5:    c = '{8'd246, 8'd104, 8'd74};
            4'd6:    c = '{8'd250, 8'd149, 8'd241};
            4'd7:    c = '{8'd232, 8'd212, 8'd253};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    // Largest y with (2y-1)^5 * depth^4 <= 2^85 * k^4; elaboration only.
    function automatic logic [16:0] gamma_entry(input int k, input int depth);
        logic [159:0] d4;
        logic [159:0] rhs;
        logic [159:0] p;
        logic [159:0] lhs;
        int lo;
        int hi;
        int mid;
        d4  = 160'(depth) * 160'(depth) * 160'(depth) * 160'(depth);
        rhs = (160'(k) * 160'(k) * 160'(k) * 160'(k)) << 85;
        lo  = 0;
        hi  = 65536;
        for (int n = 0; n < 18; n++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                p   = 160'(2 * mid - 1);
                lhs = p * p * p * p * p * d4;
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return lo[16:0];
    endfunction

endpackage

// File: design/acrm_div_cell.sv
// One restoring division step of the normalization chain.
module acrm_div_cell #(
    parameter int ATTR_WIDTH = acrm_pkg::AttrWidthDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ATTR_WIDTH-1:0]   in_rem,
    input  logic [ATTR_WIDTH-1:0]   in_den,
    input  logic [15:0]             in_quo,
    input  acrm_pkg::flags_t        in_flags,
    output logic                    out_valid,
    output logic [ATTR_WIDTH-1:0]   out_rem,
    output logic [ATTR_WIDTH-1:0]   out_den,
    output logic [15:0]             out_quo,
    output acrm_pkg::flags_t        out_flags
);
    logic                  valid_reg;
    logic [ATTR_WIDTH-1:0] rem_reg, rem_next, den_reg;
    logic [15:0]           quo_reg, quo_next;
    acrm_pkg::flags_t      flags_reg;
    logic [ATTR_WIDTH:0]   shifted;

    always_comb begin
        shifted = {in_rem, 1'b0};
        if (shifted >= {1'b0, in_den}) begin
            rem_next = ATTR_WIDTH'(shifted - {1'b0, in_den});
            quo_next = {in_quo[14:0], 1'b1};
        end else begin
            rem_next = shifted[ATTR_WIDTH-1:0];
            quo_next = {in_quo[14:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            den_reg   <= in_den;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;
endmodule

// File: design/acrm_gamma_rom.sv
// Power-0.8 curve table with registered read.
module acrm_gamma_rom #(
    parameter int GAMMA_TABLE_DEPTH = acrm_pkg::GammaTableDepthDefault
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] s_frac,
    output logic [16:0] rd_data
);
    localparam int AddrW = $clog2(GAMMA_TABLE_DEPTH);
    localparam int ProdW = 16 + $clog2(GAMMA_TABLE_DEPTH + 1);

    typedef logic [16:0] tbl_t [GAMMA_TABLE_DEPTH];

    function automatic tbl_t build_table();
        tbl_t t;
        for (int k = 0; k < GAMMA_TABLE_DEPTH; k++) begin
            t[k] = acrm_pkg::gamma_entry(k, GAMMA_TABLE_DEPTH);
        end
        return t;
    endfunction

    localparam tbl_t Table = build_table();

    logic [ProdW-1:0] prod;
    logic [AddrW-1:0] addr;
    logic [16:0]      rd_reg;

    assign prod = ProdW'(s_frac) * ProdW'(GAMMA_TABLE_DEPTH);
    assign addr = AddrW'(prod >> 16);

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_reg <= Table[addr];
        end
    end

    assign rd_data = rd_reg;
endmodule

// File: design/acrm_interp.sv
// Segment select and linear blend between two neighboring color stops.
module acrm_interp (
    input  logic [16:0]      s_norm,
    input  acrm_pkg::flags_t flags,
    output acrm_pkg::rgb_t   color,
    output logic [1:0]       status
);
    logic [3:0]        seg;
    logic [13:0]       t;
    acrm_pkg::rgb_t    c0, c1;
    logic [7:0]        a [3];
    logic [7:0]        b [3];
    logic [7:0]        r [3];
    logic signed [8:0]  d [3];
    logic signed [24:0] v [3];

    always_comb begin
        seg = (s_norm[16:13] > 4'd7) ? 4'd7 : s_norm[16:13];
        t   = 14'(s_norm - {seg[2:0], 13'd0});
        c0  = acrm_pkg::ramp_stop(seg);
        c1  = acrm_pkg::ramp_stop(seg + 4'd1);
        a[0] = c0.red;   a[1] = c0.green;  a[2] = c0.blue;
        b[0] = c1.red;   b[1] = c1.green;  b[2] = c1.blue;
        for (int c = 0; c < 3; c++) begin
            d[c] = $signed({1'b0, b[c]}) - $signed({1'b0, a[c]});
            v[c] = ($signed({11'd0, t}) * 25'(d[c])) + 25'sd4096;
            r[c] = 8'(v[c] >>> 13) + a[c];
        end
        if (flags.below) begin
            color  = acrm_pkg::ramp_stop(4'd0);
            status = acrm_pkg::RangeBelow;
        end else if (flags.above) begin
            color  = acrm_pkg::ramp_stop(4'd8);
            status = acrm_pkg::RangeAbove;
        end else if (flags.empty) begin
            color  = acrm_pkg::ramp_stop(4'd0);
            status = acrm_pkg::RangeIn;
        end else begin
            color  = '{r[0], r[1], r[2]};
            status = acrm_pkg::RangeIn;
        end
    end
endmodule

// File: design/attribute_to_color_ramp_unit.sv
// Top level: streaming attribute to RGB color ramp with a divider cell chain.
//
//  channel | ports                                  | dir | word
//  --------+----------------------------------------+-----+--------------------------
//  s_      | s_valid s_ready s_attribute            | in  | one attribute sample
//  m_      | m_valid m_ready m_red m_green m_blue   | out | one color and range status
//          | m_range_status                         |     |
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | in  | one register write
//
// One word enters per cycle unless stalled. Stages: front compare stage, sixteen
// division cells (one quotient bit each), table read stage, blend/output stage.
// Reset (aresetn low, synchronous) clears all valid flags, restores config registers.
// The whole pipe advances when the output register is empty or being taken;
// a stall on m_ready freezes every stage and drops s_ready.
// cfg_ready is always high.
module attribute_to_color_ramp_unit #(
    parameter int GAMMA_TABLE_DEPTH = acrm_pkg::GammaTableDepthDefault,
    parameter int ATTR_WIDTH        = acrm_pkg::AttrWidthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_attribute,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [1:0]  m_range_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int ExtW   = (ATTR_WIDTH > 32) ? ATTR_WIDTH : 32;
    localparam int Stages = 16;

    logic        [31:0] min_reg, max_reg;
    logic               gamma_reg;
    logic               adv;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= 32'd0;
            max_reg   <= 32'd65535;
            gamma_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                acrm_pkg::CfgMin:   min_reg   <= cfg_data;
                acrm_pkg::CfgMax:   max_reg   <= cfg_data;
                acrm_pkg::CfgGamma: gamma_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // Order-preserving code: sign extend, keep low ATTR_WIDTH bits, flip the sign bit.
    function automatic logic [ATTR_WIDTH-1:0] ord_code(input logic [31:0] v);
        logic [ExtW-1:0] e;
        e = ExtW'($signed(v));
        return e[ATTR_WIDTH-1:0] ^ {1'b1, {(ATTR_WIDTH-1){1'b0}}};
    endfunction

    logic [ATTR_WIDTH-1:0] x_code, lo_code, hi_code;
    acrm_pkg::flags_t      front_flags;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_comb begin
        x_code  = ord_code(s_attribute);
        lo_code = ord_code(min_reg);
        hi_code = ord_code(max_reg);
        front_flags.below = x_code < lo_code;
        front_flags.above = x_code > hi_code;
        front_flags.empty = hi_code == lo_code;
        front_flags.full  = x_code == hi_code;
    end

    // Front stage: hold numerator and denominator for the division chain.
    logic                  f_valid_reg;
    logic [ATTR_WIDTH-1:0] f_num_reg, f_den_reg;
    acrm_pkg::flags_t      f_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_num_reg   <= x_code - lo_code;
            f_den_reg   <= hi_code - lo_code;
            f_flags_reg <= front_flags;
        end
    end

    // Division chain: one quotient bit per cell.
    logic                  c_valid [Stages+1];
    logic [ATTR_WIDTH-1:0] c_rem   [Stages+1];
    logic [ATTR_WIDTH-1:0] c_den   [Stages+1];
    logic [15:0]           c_quo   [Stages+1];
    acrm_pkg::flags_t      c_flags [Stages+1];

    assign c_valid[0] = f_valid_reg;
    assign c_rem[0]   = f_num_reg;
    assign c_den[0]   = f_den_reg;
    assign c_quo[0]   = 16'd0;
    assign c_flags[0] = f_flags_reg;

    for (genvar g = 0; g < Stages; g++) begin : g_div
        acrm_div_cell #(.ATTR_WIDTH(ATTR_WIDTH)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (c_valid[g]),
            .in_rem    (c_rem[g]),
            .in_den    (c_den[g]),
            .in_quo    (c_quo[g]),
            .in_flags  (c_flags[g]),
            .out_valid (c_valid[g+1]),
            .out_rem   (c_rem[g+1]),
            .out_den   (c_den[g+1]),
            .out_quo   (c_quo[g+1]),
            .out_flags (c_flags[g+1])
        );
    end

    // Normalized value; a sample at max gives exactly one.
    logic [16:0] s_lin;
    assign s_lin = c_flags[Stages].full ? 17'h10000 : {1'b0, c_quo[Stages]};

    // Table read stage
    logic             t_valid_reg;
    logic [16:0]      t_s_reg;
    acrm_pkg::flags_t t_flags_reg;
    logic [16:0]      rom_q;

    acrm_gamma_rom #(.GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH)) u_rom (
        .aclk    (aclk),
        .en      (adv),
        .s_frac  (s_lin[15:0]),
        .rd_data (rom_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else if (adv) begin
            t_valid_reg <= c_valid[Stages];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_s_reg     <= s_lin;
            t_flags_reg <= c_flags[Stages];
        end
    end

    // Bypass the curve when gamma is off or the value is exactly one.
    logic [16:0]    s_eff;
    acrm_pkg::rgb_t color;
    logic [1:0]     status;

    assign s_eff = (gamma_reg && !t_s_reg[16]) ? rom_q : t_s_reg;

    acrm_interp u_interp (
        .s_norm (s_eff),
        .flags  (t_flags_reg),
        .color  (color),
        .status (status)
    );

    // Output register
    logic           o_valid_reg;
    acrm_pkg::rgb_t o_color_reg;
    logic [1:0]     o_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            o_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_color_reg  <= color;
            o_status_reg <= status;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_red          = o_color_reg.red;
    assign m_green        = o_color_reg.green;
    assign m_blue         = o_color_reg.blue;
    assign m_range_status = o_status_reg;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_range_status != 2'd3))
        else $error("range status code out of set");

    a_below_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_range_status == acrm_pkg::RangeBelow)
            |-> (m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0))
        else $error("below-range word not black");

    a_above_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_range_status == acrm_pkg::RangeAbove)
            |-> (m_red == 8'd255 && m_green == 8'd255 && m_blue == 8'd255))
        else $error("above-range word not white");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(t_valid_reg) && $stable(f_valid_reg))
        else $error("pipe moved during stall");
endmodule
